// ----- sv/wbpm_pkg.sv -----
package wbpm_pkg;

  // names kept per table entry and fixed port field widths
  localparam int NAMES_PER_ENTRY = 4;
  localparam int PORT_NAME_W     = 40;
  localparam int PARAM_W         = 64;
  localparam int INDEX_W         = 6;
  localparam int IN_DATA_W       = NAMES_PER_ENTRY * PORT_NAME_W + PARAM_W;
  localparam int OUT_DATA_W      = 72;
  localparam int OUT_PAD_W       = OUT_DATA_W - PARAM_W - INDEX_W;
  localparam int OUT_USER_W      = 3;
  localparam int KIND_W          = 3;

  // bond kinds
  localparam logic [KIND_W-1:0] KIND_SINGLE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PAIR     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ANGLE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DIHEDRAL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_IMPROPER = 3'd4;

  // operation select on the input tuser
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_MATCH = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

endpackage

// ----- sv/wildcard_bond_parameter_match.sv -----
// Bond parameter table with wildcard lookup. An insert (s_tuser = 0) stores the entry and its
// name-reversed copy, skipping exact duplicates, and returns one result with status ok or
// table full. A lookup (s_tuser = 1) returns every entry that matches the query with the fewest
// wildcard names, in table order, one result per transaction with tlast on the final one; an
// empty table or no match gives a single status-only result. The table lives in one
// single-port RAM with registered read; a single compare unit checks one entry per cycle in
// the first scan. An insert scans the table for duplicates, then writes the forward and the
// reversed copy before its result. A lookup scans the table for the best wildcard count, then
// reads the entries again up to the last best match, or gives a status-only result; a lookup
// on an empty table answers without a scan. Output stalls hold the second pass and the result.
// Write bond_kind through the cfg port only while idle; the block itself does not enforce this.
module wildcard_bond_parameter_match
  import wbpm_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int NAME_BYTES  = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // name_a, name_b, name_c, name_d, param_value
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // func
  input  logic [0:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // entry_index, param_out, 2 bits zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  // status, found
  output logic [OUT_USER_W-1:0] m_tuser,
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [KIND_W-1:0]     cfg_data
);

  localparam int NW = 8 * NAME_BYTES;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = NAMES_PER_ENTRY * NW + PARAM_W;
  localparam logic [NW-1:0] WILD = NW'(64'h58 << (NW - 8));
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [2:0] BEST_NONE = 3'd7;

  typedef logic [NAMES_PER_ENTRY-1:0][NW-1:0] names_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_WR_FWD, S_WR_REV, S_RESP, S_P2_RD, S_P2_EV
  } state_t;

  function automatic names_t reverse_names(input logic [KIND_W-1:0] kind, input names_t src);
    names_t dst;
    dst = src;
    case (kind)
      KIND_ANGLE: begin
        dst[0] = src[2];
        dst[2] = src[0];
      end
      KIND_DIHEDRAL: begin
        dst[0] = src[3];
        dst[3] = src[0];
        dst[1] = src[2];
        dst[2] = src[1];
      end
      KIND_IMPROPER: begin
        dst[0] = src[3];
        dst[3] = src[0];
      end
      default: begin
        dst[0] = src[1];
        dst[1] = src[0];
      end
    endcase
    return dst;
  endfunction

  state_t                    state;
  logic [KIND_W-1:0]         bond_kind;
  logic [CW-1:0]             count;
  logic [CW-1:0]             ptr;
  logic                      rd_pend;
  logic [AW-1:0]             rd_idx;
  names_t                    q_names;
  names_t                    r_names;
  logic [PARAM_W-1:0]        q_param;
  logic                      is_lookup;
  logic [NAMES_PER_ENTRY-1:0] used;
  logic                      dup_f;
  logic                      dup_r;
  logic                      fail;
  logic [2:0]                best;
  logic [AW-1:0]             last_idx;
  status_t                   resp_status;
  status_t                   out_status;
  logic                      out_found;
  logic [INDEX_W-1:0]        out_index;
  logic [PARAM_W-1:0]        out_param;

  // input decode
  logic [KIND_W-1:0]          kind_in;
  logic [NAMES_PER_ENTRY-1:0] used_in;
  names_t                     in_names;
  logic [63:0]                wide_name;

  always_comb begin
    kind_in = (bond_kind > KIND_IMPROPER) ? KIND_SINGLE : bond_kind;
    case (kind_in)
      KIND_ANGLE:    used_in = 4'b0111;
      KIND_DIHEDRAL: used_in = 4'b1111;
      KIND_IMPROPER: used_in = 4'b1111;
      default:       used_in = 4'b0011;
    endcase
    wide_name = '0;
    for (int i = 0; i < NAMES_PER_ENTRY; i++) begin
      wide_name = 64'(s_tdata[i*PORT_NAME_W +: PORT_NAME_W]);
      in_names[i] = used_in[i] ? wide_name[NW-1:0] : '0;
    end
  end

  // table ram
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  wbpm_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // shared entry compare unit
  names_t             e_names;
  logic [PARAM_W-1:0] e_param;
  logic               match_f;
  logic               match_r;
  logic               lk_match;
  logic [2:0]         lk_wild;
  logic               same;
  logic               eq_q;
  logic               is_wild;

  always_comb begin
    e_names  = ram_rdata[NAMES_PER_ENTRY*NW-1:0];
    e_param  = ram_rdata[EW-1 -: PARAM_W];
    match_f  = (e_param == q_param);
    match_r  = (e_param == q_param);
    lk_match = 1'b1;
    lk_wild  = '0;
    same     = 1'b1;
    eq_q     = 1'b0;
    is_wild  = 1'b0;
    for (int i = 0; i < NAMES_PER_ENTRY; i++) begin
      eq_q    = (e_names[i] == q_names[i]);
      is_wild = (e_names[i] == WILD);
      if (used[i]) begin
        if (!eq_q) match_f = 1'b0;
        if (e_names[i] != r_names[i]) match_r = 1'b0;
        if (!eq_q && !is_wild) lk_match = 1'b0;
        if (!eq_q && is_wild) lk_wild = lk_wild + 3'd1;
        if (q_names[i] != r_names[i]) same = 1'b0;
      end
    end
  end

  // ram port control
  logic issue;
  logic fwd_store;
  logic rev_store;
  logic room;
  logic out_free;
  logic out_load;
  logic p2_hit;
  logic p2_last;

  always_comb begin
    issue     = (ptr < count);
    room      = (count < DEPTH_C);
    fwd_store = !dup_f;
    rev_store = !same && !dup_r;
    out_free  = !m_tvalid || m_tready;
    p2_hit    = lk_match && (lk_wild == best);
    p2_last   = (ptr[AW-1:0] == last_idx);
    out_load  = out_free && ((state == S_RESP) || (state == S_P2_EV && p2_hit));
    ram_we    = 1'b0;
    ram_addr  = ptr[AW-1:0];
    ram_wdata = {q_param, q_names};
    case (state)
      S_WR_FWD: begin
        ram_we   = fwd_store && room;
        ram_addr = count[AW-1:0];
      end
      S_WR_REV: begin
        ram_we    = rev_store && room;
        ram_addr  = count[AW-1:0];
        ram_wdata = {q_param, r_names};
      end
      default: ram_we = 1'b0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bond_kind <= KIND_SINGLE;
      count     <= '0;
      rd_pend   <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        bond_kind <= cfg_data;
      end
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          rd_pend <= 1'b0;
          if (s_tvalid) begin
            q_names   <= in_names;
            r_names   <= reverse_names(kind_in, in_names);
            q_param   <= s_tdata[IN_DATA_W-1 -: PARAM_W];
            is_lookup <= (s_tuser[0] == FUNC_LOOKUP);
            used      <= used_in;
            ptr       <= '0;
            dup_f     <= 1'b0;
            dup_r     <= 1'b0;
            fail      <= 1'b0;
            best      <= BEST_NONE;
            last_idx  <= '0;
            if (s_tuser[0] == FUNC_LOOKUP && count == '0) begin
              resp_status <= ST_EMPTY;
              state       <= S_RESP;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // address one entry per cycle, compare it the cycle after
          rd_pend <= issue;
          rd_idx  <= ptr[AW-1:0];
          if (issue) begin
            ptr <= ptr + CW'(1);
          end
          if (rd_pend) begin
            if (!is_lookup) begin
              if (match_f) dup_f <= 1'b1;
              if (match_r) dup_r <= 1'b1;
            end else if (lk_match && lk_wild <= best) begin
              best     <= lk_wild;
              last_idx <= rd_idx;
            end
          end
          if (!issue && !rd_pend) begin
            if (!is_lookup) begin
              state <= S_WR_FWD;
            end else if (best == BEST_NONE) begin
              resp_status <= ST_NO_MATCH;
              state       <= S_RESP;
            end else begin
              ptr   <= '0;
              state <= S_P2_RD;
            end
          end
        end
        S_WR_FWD: begin
          if (fwd_store) begin
            if (room) count <= count + CW'(1);
            else      fail  <= 1'b1;
          end
          state <= S_WR_REV;
        end
        S_WR_REV: begin
          if (rev_store && room) begin
            count <= count + CW'(1);
          end
          resp_status <= (fail || (rev_store && !room)) ? ST_FULL : ST_OK;
          state       <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            out_status <= resp_status;
            out_found  <= 1'b0;
            out_index  <= '0;
            out_param  <= '0;
            m_tlast    <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_P2_RD: begin
          state <= S_P2_EV;
        end
        S_P2_EV: begin
          // second pass emits entries with the best wildcard count
          if (p2_hit) begin
            if (out_free) begin
              m_tvalid   <= 1'b1;
              out_status <= ST_OK;
              out_found  <= 1'b1;
              out_index  <= INDEX_W'(ptr[AW-1:0]);
              out_param  <= e_param;
              m_tlast    <= p2_last;
              if (p2_last) begin
                state <= S_IDLE;
              end else begin
                ptr   <= ptr + CW'(1);
                state <= S_P2_RD;
              end
            end
          end else begin
            ptr   <= ptr + CW'(1);
            state <= S_P2_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ports
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = {{OUT_PAD_W{1'b0}}, out_param, out_index};
  assign m_tuser   = {out_found, out_status};

endmodule

// ----- sv/wbpm_ram.sv -----
module wbpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- sv/wbpm_checker.sv -----
module wbpm_checker
  import wbpm_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [OUT_USER_W-1:0] m_tuser,
  input logic                  m_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // a matching entry always carries status ok
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tuser[1:0] == ST_OK)
    else $error("found result with non-ok status");

  // a status-only result is the final result, with no payload
  a_nofound_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[2] |-> m_tlast && m_tdata == '0)
    else $error("status-only result not final or carries payload");

  // a found result is the final result or carries status ok
  a_insert_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tlast || m_tuser[1:0] == ST_OK)
    else $error("found result with bad framing");

  // the block takes one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while busy");

endmodule

bind wildcard_bond_parameter_match wbpm_checker u_wbpm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
